// ===== src/trapezoid_point_to_point_trajectory_macros.svh =====
// assertion helpers for the trajectory block
`ifndef TRAPEZOID_POINT_TO_POINT_TRAJECTORY_MACROS_SVH
`define TRAPEZOID_POINT_TO_POINT_TRAJECTORY_MACROS_SVH

`ifndef SYNTH
`define TPPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tppt assertion failed");
`define TPPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tppt assertion failed");
`else
`define TPPT_ASSERT_IMP(lbl, ante, cons)
`define TPPT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/tppt_pkg.sv =====
package tppt_pkg;

  localparam int NUM_W = 96;
  localparam int DEN_W = 66;
  localparam int QUO_W = 41;
  localparam logic [QUO_W:0] QUO_CAP = (QUO_W+1)'(1) << (QUO_W - 1);

  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;

  localparam logic [3:0] REG_TOTAL   = 4'd0;
  localparam logic [3:0] REG_RAMP    = 4'd1;
  localparam logic [3:0] REG_START_X = 4'd2;
  localparam logic [3:0] REG_START_Y = 4'd3;
  localparam logic [3:0] REG_START_Z = 4'd4;
  localparam logic [3:0] REG_GOAL_X  = 4'd5;
  localparam logic [3:0] REG_GOAL_Y  = 4'd6;
  localparam logic [3:0] REG_GOAL_Z  = 4'd7;

  localparam logic [31:0] TOTAL_RST = 32'd131072;
  localparam logic [31:0] RAMP_RST  = 32'd32768;
  localparam logic [1:0]  SETTLE    = 2'd3;

  typedef struct packed {
    logic [1:0] ph;
    logic       late;
  } tag_t;

  function automatic logic [31:0] sat32(input logic signed [42:0] v);
    logic [31:0] r;
    if (v > 43'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -43'sh0_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== src/trapezoid_point_to_point_trajectory.sv =====
// each sample passes input, phase, square, product, operand, divider and output registers
// throughput: one sample per cycle unless busy, set by the 41-step pipelined divider lanes
// reset: loads the default registers, empties the pipeline and holds busy while
//   derived products settle; each config write holds busy the same way
// the receiver cannot stall: every result shows for one cycle with strobe high
module trapezoid_point_to_point_trajectory import tppt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample_time,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        strobe,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] pos_z,
  output logic [31:0] vel_x,
  output logic [31:0] vel_y,
  output logic [31:0] vel_z,
  output logic [31:0] acc_x,
  output logic [31:0] acc_y,
  output logic [31:0] acc_z,
  output logic [1:0]  phase,
  output logic        bad_timing
);

  `include "trapezoid_point_to_point_trajectory_macros.svh"

  logic [31:0] total, ramp;
  logic [31:0] start_c [3];
  logic [31:0] goal_c  [3];
  logic [1:0]  settle;
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = settle != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= TOTAL_RST;
      ramp    <= RAMP_RST;
      start_c <= '{default: '0};
      goal_c  <= '{default: '0};
      settle  <= SETTLE;
    end else begin
      if (cfg_wr) begin
        settle <= SETTLE;
        unique case (cfg_index)
          REG_TOTAL:   total      <= cfg_data;
          REG_RAMP:    ramp       <= cfg_data;
          REG_START_X: start_c[0] <= cfg_data;
          REG_START_Y: start_c[1] <= cfg_data;
          REG_START_Z: start_c[2] <= cfg_data;
          REG_GOAL_X:  goal_c[0]  <= cfg_data;
          REG_GOAL_Y:  goal_c[1]  <= cfg_data;
          REG_GOAL_Z:  goal_c[2]  <= cfg_data;
          default: ;
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  // values that follow from the registers alone
  logic [31:0] rest;
  logic [63:0] prod;
  logic        bad;
  logic [31:0] mag [3];
  logic        neg [3];

  always_ff @(posedge clk) begin
    rest <= total - ramp;
    bad  <= (ramp == 32'd0) || (ramp >= total);
    prod <= {32'd0, ramp} * {32'd0, rest};
  end

  for (genvar a = 0; a < 3; a++) begin : g_span
    logic [32:0] d;
    logic [32:0] dn;
    assign d  = {goal_c[a][31], goal_c[a]} - {start_c[a][31], start_c[a]};
    assign dn = -d;
    always_ff @(posedge clk) begin
      neg[a] <= d[32];
      mag[a] <= d[32] ? dn[31:0] : d[31:0];
    end
  end

  logic        v1, v2, v3;
  logic [31:0] t1;
  tag_t        tag2, tag3;
  logic [32:0] x2, x3;
  logic [63:0] sq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    t1 <= sample_time;
  end

  logic [1:0]  ph1;
  logic        late1;
  logic [31:0] tau1;
  logic [32:0] x1;

  always_comb begin
    if (t1 <= ramp) ph1 = PH_ACCEL;
    else if (t1 <= rest) ph1 = PH_CRUISE;
    else ph1 = PH_DECEL;
    late1 = t1 > total;
    tau1  = late1 ? t1 - total : total - t1;
    case (ph1)
      PH_ACCEL:  x1 = {1'b0, t1};
      PH_CRUISE: x1 = {t1, 1'b0} - {1'b0, ramp};
      default:   x1 = {1'b0, tau1};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
    end
    tag2 <= '{ph: ph1, late: late1};
    x2   <= x1;
    tag3 <= tag2;
    x3   <= x2;
    sq3  <= {32'd0, x2[31:0]} * {32'd0, x2[31:0]};
  end

  logic [31:0] pos_a [3];
  logic [31:0] vel_a [3];
  logic [31:0] acc_a [3];

  tppt_axis u_axis_x (
    .clk(clk), .rst(rst), .in_valid(v3), .in_tag(tag3), .x(x3), .sq(sq3),
    .mag(mag[0]), .neg(neg[0]), .sbase(start_c[0]), .gbase(goal_c[0]),
    .rest(rest), .prod(prod), .bad(bad),
    .ovalid(strobe), .ophase(phase), .obad(bad_timing),
    .pos(pos_a[0]), .vel(vel_a[0]), .acc(acc_a[0])
  );
  tppt_axis u_axis_y (
    .clk(clk), .rst(rst), .in_valid(v3), .in_tag(tag3), .x(x3), .sq(sq3),
    .mag(mag[1]), .neg(neg[1]), .sbase(start_c[1]), .gbase(goal_c[1]),
    .rest(rest), .prod(prod), .bad(bad),
    .ovalid(), .ophase(), .obad(),
    .pos(pos_a[1]), .vel(vel_a[1]), .acc(acc_a[1])
  );
  tppt_axis u_axis_z (
    .clk(clk), .rst(rst), .in_valid(v3), .in_tag(tag3), .x(x3), .sq(sq3),
    .mag(mag[2]), .neg(neg[2]), .sbase(start_c[2]), .gbase(goal_c[2]),
    .rest(rest), .prod(prod), .bad(bad),
    .ovalid(), .ophase(), .obad(),
    .pos(pos_a[2]), .vel(vel_a[2]), .acc(acc_a[2])
  );

  assign pos_x = pos_a[0];
  assign pos_y = pos_a[1];
  assign pos_z = pos_a[2];
  assign vel_x = vel_a[0];
  assign vel_y = vel_a[1];
  assign vel_z = vel_a[2];
  assign acc_x = acc_a[0];
  assign acc_y = acc_a[1];
  assign acc_z = acc_a[2];

  `TPPT_ASSERT_NEXT(a_busy_after_cfg, cfg_wr, busy)
  `TPPT_ASSERT_IMP(a_bad_zero, strobe && bad_timing, phase == PH_ACCEL && vel_y == '0)
  `TPPT_ASSERT_IMP(a_cruise_acc, strobe && !bad_timing && phase == PH_CRUISE, acc_x == '0)

endmodule

// ===== src/tppt_div.sv =====
module tppt_div import tppt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  tag_t             in_tag,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_valid,
  output tag_t             out_tag,
  output logic [QUO_W-1:0] quo
);

  logic             sv   [QUO_W+1];
  tag_t             stag [QUO_W+1];
  logic             sovf [QUO_W+1];
  logic [DEN_W-1:0] sden [QUO_W+1];
  logic [DEN_W-1:0] srem [QUO_W+1];
  logic [QUO_W-1:0] squo [QUO_W+1];
  logic [QUO_W-1:0] slow [QUO_W];

  // quotient of 2^41 or more always ends at the cap
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= in_valid;
    end
    stag[0] <= in_tag;
    sovf[0] <= {{(DEN_W+QUO_W-NUM_W){1'b0}}, num} >= {den, {QUO_W{1'b0}}};
    sden[0] <= den;
    srem[0] <= {{(DEN_W-(NUM_W-QUO_W)){1'b0}}, num[NUM_W-1:QUO_W]};
    squo[0] <= '0;
    slow[0] <= num[QUO_W-1:0];
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0] r2;
    logic [DEN_W:0] diff;
    logic           ge;
    assign r2   = {srem[k], slow[k][QUO_W-1]};
    assign diff = r2 - {1'b0, sden[k]};
    assign ge   = r2 >= {1'b0, sden[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else begin
        sv[k+1] <= sv[k];
      end
      stag[k+1] <= stag[k];
      sovf[k+1] <= sovf[k];
      sden[k+1] <= sden[k];
      srem[k+1] <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      squo[k+1] <= {squo[k][QUO_W-2:0], ge};
    end
    if (k < QUO_W - 1) begin : g_low
      always_ff @(posedge clk) begin
        slow[k+1] <= {slow[k][QUO_W-2:0], 1'b0};
      end
    end
  end

  logic           up;
  logic [QUO_W:0] rounded;
  assign up      = srem[QUO_W] >= (sden[QUO_W] - srem[QUO_W]);
  assign rounded = {1'b0, squo[QUO_W]} + {{QUO_W{1'b0}}, up};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sv[QUO_W];
    end
    out_tag <= stag[QUO_W];
    if (sovf[QUO_W] || rounded > QUO_CAP) quo <= QUO_CAP[QUO_W-1:0];
    else quo <= rounded[QUO_W-1:0];
  end

endmodule

// ===== src/tppt_axis.sv =====
module tppt_axis import tppt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  tag_t        in_tag,
  input  logic [32:0] x,
  input  logic [63:0] sq,
  input  logic [31:0] mag,
  input  logic        neg,
  input  logic [31:0] sbase,
  input  logic [31:0] gbase,
  input  logic [31:0] rest,
  input  logic [63:0] prod,
  input  logic        bad,
  output logic        ovalid,
  output logic [1:0]  ophase,
  output logic        obad,
  output logic [31:0] pos,
  output logic [31:0] vel,
  output logic [31:0] acc
);

  logic        v4;
  tag_t        tag4;
  logic [63:0] plo, phi;
  logic [64:0] px;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= in_valid;
    end
    tag4 <= in_tag;
    plo  <= {32'd0, mag} * {32'd0, sq[31:0]};
    phi  <= {32'd0, mag} * {32'd0, sq[63:32]};
    px   <= {33'd0, mag} * {32'd0, x};
  end

  logic             v5;
  tag_t             tag5;
  logic [NUM_W-1:0] npos, nvel, nacc;
  logic [DEN_W-1:0] dpos, dvel, dacc;
  logic             cru4;
  assign cru4 = tag4.ph == PH_CRUISE;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    tag5 <= tag4;
    npos <= cru4 ? {31'd0, px} : ({32'd0, plo} + {phi, 32'd0});
    nvel <= cru4 ? {48'd0, mag, 16'd0} : {15'd0, px, 16'd0};
    nacc <= {32'd0, mag, 32'd0};
    dpos <= cru4 ? {33'd0, rest, 1'b0} : {1'b0, prod, 1'b0};
    dvel <= cru4 ? {34'd0, rest} : {2'd0, prod};
    dacc <= {2'd0, prod};
  end

  logic             dv, dv_v, dv_a;
  tag_t             dtag, dtag_v, dtag_a;
  logic [QUO_W-1:0] qp, qv, qa;

  tppt_div u_div_pos (
    .clk(clk), .rst(rst), .in_valid(v5), .in_tag(tag5), .num(npos), .den(dpos),
    .out_valid(dv), .out_tag(dtag), .quo(qp)
  );
  tppt_div u_div_vel (
    .clk(clk), .rst(rst), .in_valid(v5), .in_tag(tag5), .num(nvel), .den(dvel),
    .out_valid(dv_v), .out_tag(dtag_v), .quo(qv)
  );
  tppt_div u_div_acc (
    .clk(clk), .rst(rst), .in_valid(v5), .in_tag(tag5), .num(nacc), .den(dacc),
    .out_valid(dv_a), .out_tag(dtag_a), .quo(qa)
  );

  logic signed [42:0] mp, mv, ma, sp, sv, sa, base, psum;
  logic               dec, vneg, aneg;

  always_comb begin
    dec  = dtag.ph == PH_DECEL;
    mp   = signed'({2'b00, qp});
    mv   = signed'({2'b00, qv});
    ma   = signed'({2'b00, qa});
    sp   = neg ? -mp : mp;
    base = dec ? signed'({{11{gbase[31]}}, gbase}) : signed'({{11{sbase[31]}}, sbase});
    psum = dec ? base - sp : base + sp;
    vneg = dec ? (neg ^ dtag.late) : neg;
    sv   = vneg ? -mv : mv;
    aneg = dec ? !neg : neg;
    if (dtag.ph == PH_CRUISE) sa = '0;
    else sa = aneg ? -ma : ma;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else begin
      ovalid <= dv && dv_v && dv_a && (dtag_v == dtag) && (dtag_a == dtag);
    end
    obad <= bad;
    if (bad) begin
      ophase <= PH_ACCEL;
      pos    <= '0;
      vel    <= '0;
      acc    <= '0;
    end else begin
      ophase <= dtag.ph;
      pos    <= sat32(psum);
      vel    <= sat32(sv);
      acc    <= sat32(sa);
    end
  end

endmodule
